/* rtl/jpeg_header_size_scanner_top_defines.svh */
// Assertion macros used by the checker file of the JPEG header scanner.
// Depends on nothing; included by the checker module.
`ifndef JPEG_HEADER_SIZE_SCANNER_TOP_DEFINES_SVH
`define JPEG_HEADER_SIZE_SCANNER_TOP_DEFINES_SVH

// Clocked property that is ignored while reset is asserted.
`define JHSS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define JHSS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/jhss_pkg.sv */
// Types, marker constants and helper functions for the JPEG header size scanner.
// Used by the top level and by its checker; depends on nothing.
package jhss_pkg;

    typedef enum logic [3:0] {
        PH_S0,
        PH_S1,
        PH_S2,
        PH_S3,
        PH_APP0,
        PH_SKIP,
        PH_MARK0,
        PH_MARK1,
        PH_LEN,
        PH_FRAME,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_START  = 3'd1,
        ST_NO_JFIF    = 3'd2,
        ST_NO_MARKER  = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_BAD_LENGTH = 3'd5
    } t_status;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_SOI    = 8'hD8;
    localparam logic [7:0] MARKER_APP0   = 8'hE0;
    localparam logic [7:0] MARKER_SOF0   = 8'hC0;
    localparam logic [7:0] CHAR_J        = 8'h4A;
    localparam logic [7:0] CHAR_F        = 8'h46;
    localparam logic [7:0] CHAR_I        = 8'h49;

    localparam logic [16:0] PAD_MIN = 17'd2;

    // Expected byte of the "JFIF" tag at position idx.
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                2'd0:    r = CHAR_J;
                2'd1:    r = CHAR_F;
                2'd2:    r = CHAR_I;
                default: r = CHAR_F;
            endcase
            return r;
        end
    endfunction

    // Smallest power of two not below w, at least two. The bits of w - 1 are
    // smeared downward, so adding one lands on the next power of two.
    function automatic logic [16:0] pad_pow2(input logic [15:0] w);
        logic [15:0] x;
        logic [16:0] r;
        begin
            x = w - 16'd1;
            x = x | (x >> 1);
            x = x | (x >> 2);
            x = x | (x >> 4);
            x = x | (x >> 8);
            if (w <= 16'd2) r = PAD_MIN;
            else            r = {1'b0, x} + 17'd1;
            return r;
        end
    endfunction

endpackage

/* rtl/jpeg_header_size_scanner_top.sv */
// A byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle while the result side takes what it is offered;
// a result that waits holds only the byte already in the input register.
// Reset (i_rst_n low, synchronous) returns the parser to the first start byte
// and drops any pending byte and result. The last byte of a file also returns
// the parser to the first start byte. Depends on jhss_pkg.
module jpeg_header_size_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_height,
    output logic [15:0] o_width,
    output logic [16:0] o_padded_width
);
    import jhss_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;

    // Parser state
    t_phase      r_phase,     n_phase;
    logic [15:0] r_bis,       n_bis;
    logic [15:0] r_seg_len,   n_seg_len;
    logic [15:0] r_height,    n_height;
    logic [7:0]  r_width_hi,  n_width_hi;

    // Result register
    logic        r_out_valid;
    t_status     r_status;
    logic [15:0] r_height_out;
    logic [15:0] r_width_out;
    logic [16:0] r_pad_out;

    logic        advance;
    logic        step;

    logic        emit;
    t_status     e_status;
    logic [15:0] e_height;
    logic [15:0] e_width;

    logic        tag_ok;
    logic [15:0] len_new;
    logic [15:0] skip_bis;
    logic        skip_end;
    logic [15:0] frame_width;

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    assign tag_ok      = (r_in_byte == tag_byte(r_bis[1:0] - 2'd2));
    assign len_new     = {r_seg_len[15:8], r_in_byte};
    assign skip_bis    = r_bis + 16'd1;
    assign skip_end    = ({1'b0, skip_bis} + 17'd1) >= {1'b0, r_seg_len};
    assign frame_width = {r_width_hi, r_in_byte};

    // Result decision for the byte in the input register.
    always_comb begin
        emit     = 1'b0;
        e_status = ST_OK;
        e_height = 16'd0;
        e_width  = 16'd0;
        case (r_phase)
            PH_S0: if (r_in_byte != MARKER_PREFIX) begin
                emit = 1'b1; e_status = ST_BAD_START;
            end
            PH_S1: if (r_in_byte != MARKER_SOI) begin
                emit = 1'b1; e_status = ST_BAD_START;
            end
            PH_S2: if (r_in_byte != MARKER_PREFIX) begin
                emit = 1'b1; e_status = ST_BAD_START;
            end
            PH_S3: if (r_in_byte != MARKER_APP0) begin
                emit = 1'b1; e_status = ST_BAD_START;
            end
            PH_APP0: begin
                if (r_bis >= 16'd2 && !tag_ok) begin
                    emit = 1'b1; e_status = ST_NO_JFIF;
                end else if (r_bis == 16'd5) begin
                    // A short APP0 would start the next segment inside the tag.
                    if (r_seg_len < 16'd2) begin
                        emit = 1'b1; e_status = ST_BAD_LENGTH;
                    end else if (r_seg_len < 16'd6) begin
                        emit = 1'b1; e_status = ST_NO_MARKER;
                    end
                end
            end
            PH_MARK0: if (r_in_byte != MARKER_PREFIX) begin
                emit = 1'b1; e_status = ST_NO_MARKER;
            end
            PH_LEN: if (r_bis != 16'd0 && len_new < 16'd2) begin
                emit = 1'b1; e_status = ST_BAD_LENGTH;
            end
            PH_FRAME: if (r_bis == 16'd6) begin
                emit     = 1'b1;
                e_status = ST_OK;
                e_height = r_height;
                e_width  = frame_width;
            end
            default: ;
        endcase
        if (r_in_eof && !emit && r_phase != PH_DONE) begin
            emit     = 1'b1;
            e_status = ST_TRUNCATED;
        end
    end

    // Next parser state.
    always_comb begin
        n_phase    = r_phase;
        n_bis      = r_bis;
        n_seg_len  = r_seg_len;
        n_height   = r_height;
        n_width_hi = r_width_hi;
        case (r_phase)
            PH_S0: n_phase = PH_S1;
            PH_S1: n_phase = PH_S2;
            PH_S2: n_phase = PH_S3;
            PH_S3: begin
                n_phase   = PH_APP0;
                n_bis     = 16'd0;
                n_seg_len = 16'd0;
            end
            PH_APP0: begin
                if (r_bis == 16'd0)      n_seg_len = {r_in_byte, 8'h00};
                else if (r_bis == 16'd1) n_seg_len = len_new;
                if (r_bis == 16'd5) begin
                    n_phase = (r_seg_len == 16'd6) ? PH_MARK0 : PH_SKIP;
                end else begin
                    n_bis = r_bis + 16'd1;
                end
            end
            PH_SKIP: begin
                n_bis = skip_bis;
                if (skip_end) n_phase = PH_MARK0;
            end
            PH_MARK0: n_phase = PH_MARK1;
            PH_MARK1: begin
                n_bis   = 16'd0;
                n_phase = (r_in_byte == MARKER_SOF0) ? PH_FRAME : PH_LEN;
            end
            PH_LEN: begin
                if (r_bis == 16'd0) begin
                    n_seg_len = {r_in_byte, 8'h00};
                    n_bis     = 16'd1;
                end else begin
                    n_seg_len = len_new;
                    n_phase   = (len_new == 16'd2) ? PH_MARK0 : PH_SKIP;
                end
            end
            PH_FRAME: begin
                if (r_bis == 16'd3)      n_height   = {r_in_byte, 8'h00};
                else if (r_bis == 16'd4) n_height   = {r_height[15:8], r_in_byte};
                else if (r_bis == 16'd5) n_width_hi = r_in_byte;
                n_bis = r_bis + 16'd1;
            end
            default: n_phase = PH_DONE;
        endcase
        if (emit) n_phase = PH_DONE;
        if (r_in_eof) begin
            n_phase    = PH_S0;
            n_bis      = 16'd0;
            n_seg_len  = 16'd0;
            n_height   = 16'd0;
            n_width_hi = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_S0;
            r_bis      <= 16'd0;
            r_seg_len  <= 16'd0;
            r_height   <= 16'd0;
            r_width_hi <= 8'd0;
        end else if (step) begin
            r_phase    <= n_phase;
            r_bis      <= n_bis;
            r_seg_len  <= n_seg_len;
            r_height   <= n_height;
            r_width_hi <= n_width_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_status     <= e_status;
            r_height_out <= e_height;
            r_width_out  <= e_width;
            r_pad_out    <= (e_status == ST_OK) ? pad_pow2(e_width) : PAD_MIN;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_height       = r_height_out;
    assign o_width        = r_width_out;
    assign o_padded_width = r_pad_out;

endmodule

/* rtl/jhss_checker.sv */
// Port-level checks for the JPEG header size scanner, bound to its top level.
// Depends on jhss_pkg and jpeg_header_size_scanner_top_defines.svh.
`include "jpeg_header_size_scanner_top_defines.svh"

module jhss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_file,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [15:0] o_height,
    input logic [15:0] o_width,
    input logic [16:0] o_padded_width
);
    import jhss_pkg::*;

    // A stalled result keeps its status, width and padded width.
    `JHSS_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_width) && $stable(o_padded_width),
        "result changed while stalled")

    // Reset drops any pending result on the next edge.
    `JHSS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid,
        "result valid after reset")

    // Only the defined status codes are ever reported.
    `JHSS_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> o_status <= ST_BAD_LENGTH,
        "undefined status")

    // A good frame has a padded width that covers the width and is at least two.
    `JHSS_ASSERT(a_pad_cover, i_clk, i_rst_n,
        o_out_valid && o_status == ST_OK |-> o_padded_width >= 17'(o_width) &&
        o_padded_width >= PAD_MIN && $onehot(o_padded_width),
        "padded width wrong")

    // Errors carry zero dimensions.
    `JHSS_ASSERT(a_err_zero, i_clk, i_rst_n,
        o_out_valid && o_status != ST_OK |-> o_height == 16'd0 && o_width == 16'd0 &&
        o_padded_width == PAD_MIN,
        "error result has dimensions")

endmodule

bind jpeg_header_size_scanner_top jhss_checker u_jhss_checker (.*);

/* tb/tb_jpeg_header_size_scanner_top.sv */
// Self-checking testbench for jpeg_header_size_scanner_top: a short table of directed bytes,
// then random JPEG-like files, each report scored against the table or a bit-exact bench parser.
// Depends on jhss_pkg and the top level; needs no other file.
module tb_jpeg_header_size_scanner_top;
    import jhss_pkg::*;

    localparam int N_DIRECTED    = 30;
    localparam int RANDOM_BYTES  = 1600;
    localparam int GAP_PCT       = 21;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic [31:0] JFIF_TAG = {CHAR_J, CHAR_F, CHAR_I, CHAR_F};

    typedef struct packed {
        t_status     st;
        logic [15:0] h;
        logic [15:0] w;
        logic [16:0] pw;
    } t_size_report;

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         known;
        t_size_report rep;
    } t_stim_row;

    localparam t_size_report REP_NONE      = '{ST_OK, 16'd0, 16'd0, PAD_MIN};
    localparam t_size_report REP_BAD_START = '{ST_BAD_START, 16'd0, 16'd0, PAD_MIN};
    localparam t_size_report REP_NO_JFIF   = '{ST_NO_JFIF, 16'd0, 16'd0, PAD_MIN};
    localparam t_size_report REP_TRUNCATED = '{ST_TRUNCATED, 16'd0, 16'd0, PAD_MIN};
    localparam t_size_report REP_MAX_SIZE  = '{ST_OK, 16'hFFFF, 16'hFFFF, 17'h10000};

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_end_of_file  = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [15:0] o_height;
    logic [15:0] o_width;
    logic [16:0] o_padded_width;

    // Bad start, a maximal frame, a missing tag and a lone truncated byte.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, REP_BAD_START},
        '{8'hFF, 1'b1, 1'b0, REP_NONE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hD8, 1'b0, 1'b0, REP_NONE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hE0, 1'b0, 1'b0, REP_NONE},
        '{8'h00, 1'b0, 1'b0, REP_NONE},
        '{8'h06, 1'b0, 1'b0, REP_NONE},
        '{8'h4A, 1'b0, 1'b0, REP_NONE},
        '{8'h46, 1'b0, 1'b0, REP_NONE},
        '{8'h49, 1'b0, 1'b0, REP_NONE},
        '{8'h46, 1'b0, 1'b0, REP_NONE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hC0, 1'b0, 1'b0, REP_NONE},
        '{8'h00, 1'b0, 1'b0, REP_NONE},
        '{8'h08, 1'b0, 1'b0, REP_NONE},
        '{8'h08, 1'b0, 1'b0, REP_NONE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hFF, 1'b1, 1'b1, REP_MAX_SIZE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hD8, 1'b0, 1'b0, REP_NONE},
        '{8'hFF, 1'b0, 1'b0, REP_NONE},
        '{8'hE0, 1'b0, 1'b0, REP_NONE},
        '{8'h00, 1'b0, 1'b0, REP_NONE},
        '{8'h10, 1'b0, 1'b0, REP_NONE},
        '{8'h4A, 1'b0, 1'b0, REP_NONE},
        '{8'h00, 1'b1, 1'b1, REP_NO_JFIF},
        '{8'hFF, 1'b1, 1'b1, REP_TRUNCATED}
    };

    // Parser state of the bench, kept in step with every accepted byte.
    t_phase      scan_phase    = PH_S0;
    logic [15:0] scan_pos      = 16'd0;
    logic [15:0] scan_len      = 16'd0;
    logic [15:0] scan_height   = 16'd0;
    logic [15:0] scan_width_hi = 16'd0;
    logic        scan_done     = 1'b0;

    t_size_report pending_reports [$];
    logic [7:0]   file_bytes [$];
    int           bytes_sent   = 0;
    int           files_sent   = 0;
    int           reports_seen = 0;
    int           ok_seen      = 0;
    int           n_errors     = 0;
    int           cycle_count  = 0;
    logic         hold_off     = 1'b0;
    logic         drained_mid  = 1'b0;

    jpeg_header_size_scanner_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_file  (i_end_of_file),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_height       (o_height),
        .o_width        (o_width),
        .o_padded_width (o_padded_width)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Works out the size report, if any, that one byte of the file causes.
    task scan_byte(input logic [7:0] b, input logic e, output logic got,
                   output t_size_report rep);
        logic [1:0]  tag_idx;
        logic [7:0]  tag_exp;
        logic [15:0] wv;
        logic [16:0] pw;
        begin
            got     = 1'b0;
            rep     = REP_NONE;
            tag_idx = scan_pos[1:0] - 2'd2;
            tag_exp = JFIF_TAG[8 * (3 - tag_idx) +: 8];
            case (scan_phase)
                PH_S0: begin
                    if (b != MARKER_PREFIX) begin rep.st = ST_BAD_START; got = 1'b1; end
                    else scan_phase = PH_S1;
                end
                PH_S1: begin
                    if (b != MARKER_SOI) begin rep.st = ST_BAD_START; got = 1'b1; end
                    else scan_phase = PH_S2;
                end
                PH_S2: begin
                    if (b != MARKER_PREFIX) begin rep.st = ST_BAD_START; got = 1'b1; end
                    else scan_phase = PH_S3;
                end
                PH_S3: begin
                    if (b != MARKER_APP0) begin
                        rep.st = ST_BAD_START;
                        got    = 1'b1;
                    end else begin
                        scan_phase = PH_APP0;
                        scan_pos   = 16'd0;
                        scan_len   = 16'd0;
                    end
                end
                PH_APP0: begin
                    if (scan_pos >= 16'd2 && b != tag_exp) begin
                        rep.st = ST_NO_JFIF;
                        got    = 1'b1;
                    end else begin
                        if (scan_pos == 16'd0) scan_len = {b, 8'h00};
                        else if (scan_pos == 16'd1) scan_len = scan_len | {8'h00, b};
                        // The length is only judged once the whole tag has been seen.
                        if (scan_pos == 16'd5) begin
                            if (scan_len < 16'd2) begin rep.st = ST_BAD_LENGTH; got = 1'b1; end
                            else if (scan_len < 16'd6) begin
                                rep.st = ST_NO_MARKER;
                                got    = 1'b1;
                            end
                            else if (scan_len == 16'd6) scan_phase = PH_MARK0;
                            else scan_phase = PH_SKIP;
                        end else begin
                            scan_pos = scan_pos + 16'd1;
                        end
                    end
                end
                PH_SKIP: begin
                    scan_pos = scan_pos + 16'd1;
                    if ({1'b0, scan_pos} + 17'd1 >= {1'b0, scan_len}) scan_phase = PH_MARK0;
                end
                PH_MARK0: begin
                    if (b != MARKER_PREFIX) begin rep.st = ST_NO_MARKER; got = 1'b1; end
                    else scan_phase = PH_MARK1;
                end
                PH_MARK1: begin
                    scan_pos   = 16'd0;
                    scan_phase = (b == MARKER_SOF0) ? PH_FRAME : PH_LEN;
                end
                PH_LEN: begin
                    if (scan_pos == 16'd0) begin
                        scan_len = {b, 8'h00};
                        scan_pos = 16'd1;
                    end else begin
                        scan_len = scan_len | {8'h00, b};
                        if (scan_len < 16'd2) begin rep.st = ST_BAD_LENGTH; got = 1'b1; end
                        else if (scan_len == 16'd2) scan_phase = PH_MARK0;
                        else scan_phase = PH_SKIP;
                    end
                end
                PH_FRAME: begin
                    if (scan_pos == 16'd3) scan_height = {b, 8'h00};
                    else if (scan_pos == 16'd4) scan_height = scan_height | {8'h00, b};
                    else if (scan_pos == 16'd5) scan_width_hi = {b, 8'h00};
                    if (scan_pos == 16'd6) begin
                        wv = scan_width_hi | {8'h00, b};
                        pw = 17'd2;
                        while (pw < {1'b0, wv} && pw < 17'h10000) pw = pw << 1;
                        rep = '{ST_OK, scan_height, wv, pw};
                        got = 1'b1;
                    end else begin
                        scan_pos = scan_pos + 16'd1;
                    end
                end
                default: scan_phase = PH_DONE;
            endcase
            if (got) begin
                scan_done  = 1'b1;
                scan_phase = PH_DONE;
            end
            // The last byte of a file closes it: report truncation if nothing came yet.
            if (e) begin
                if (!got && !scan_done) begin
                    rep    = REP_TRUNCATED;
                    got    = 1'b1;
                end
                scan_phase    = PH_S0;
                scan_pos      = 16'd0;
                scan_len      = 16'd0;
                scan_height   = 16'd0;
                scan_width_hi = 16'd0;
                scan_done     = 1'b0;
            end
        end
    endtask

    // Offers one request and returns at the edge where it is taken.
    task offer_byte(input logic [7:0] b, input logic e, input logic known,
                    input t_size_report known_rep);
        logic         got;
        t_size_report rep;
        begin
            while (!(bytes_sent >= 700 && bytes_sent < 1000) && $urandom_range(0, 99) < GAP_PCT)
            begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid    <= 1'b1;
            i_data_byte   <= b;
            i_end_of_file <= e;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            bytes_sent++;
            if (e) files_sent++;
            scan_byte(b, e, got, rep);
            if (known) pending_reports.push_back(known_rep);
            else if (got) pending_reports.push_back(rep);
        end
    endtask

    // Mostly well-formed files with random content; some noise, some corrupted or cut short.
    task build_file;
        int          r;
        int          n;
        int          k;
        logic [15:0] seg_len;
        logic [15:0] hgt;
        logic [15:0] wid;
        logic [7:0]  mk;
        begin
            file_bytes.delete();
            if ($urandom_range(0, 99) < 10) begin
                n = $urandom_range(1, 8);
                repeat (n) file_bytes.push_back(8'($urandom));
            end else begin
                file_bytes.push_back(MARKER_PREFIX);
                file_bytes.push_back(MARKER_SOI);
                file_bytes.push_back(MARKER_PREFIX);
                file_bytes.push_back(MARKER_APP0);
                if ($urandom_range(0, 99) < 8) seg_len = 16'($urandom_range(0, 5));
                else seg_len = 16'(6 + $urandom_range(0, 10));
                file_bytes.push_back(seg_len[15:8]);
                file_bytes.push_back(seg_len[7:0]);
                file_bytes.push_back(CHAR_J);
                file_bytes.push_back(CHAR_F);
                file_bytes.push_back(CHAR_I);
                file_bytes.push_back(CHAR_F);
                if (seg_len > 16'd6) repeat (seg_len - 16'd6) file_bytes.push_back(8'($urandom));
                n = $urandom_range(0, 3);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 4) file_bytes.push_back(8'($urandom_range(0, 254)));
                    else file_bytes.push_back(MARKER_PREFIX);
                    mk = 8'($urandom);
                    // A fill byte in the marker slot is parsed as a marker of its own.
                    if (mk == MARKER_SOF0 || $urandom_range(0, 99) < 12) mk = MARKER_PREFIX;
                    file_bytes.push_back(mk);
                    r = $urandom_range(0, 99);
                    if (r < 5) seg_len = 16'($urandom_range(0, 1));
                    else if (r < 7) seg_len = 16'(256 + $urandom_range(0, 300));
                    else seg_len = 16'(2 + $urandom_range(0, 12));
                    file_bytes.push_back(seg_len[15:8]);
                    file_bytes.push_back(seg_len[7:0]);
                    if (seg_len > 16'd2) repeat (seg_len - 16'd2) file_bytes.push_back(8'($urandom));
                end
                case ($urandom_range(0, 7))
                    0:       hgt = 16'h0000;
                    1:       hgt = 16'hFFFF;
                    default: hgt = 16'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       wid = 16'($urandom_range(0, 3));
                    1:       wid = 16'h0001 << $urandom_range(0, 15);
                    2:       wid = (16'h0001 << $urandom_range(1, 15)) + 16'd1;
                    3:       wid = 16'hFFFF;
                    default: wid = 16'($urandom);
                endcase
                file_bytes.push_back(MARKER_PREFIX);
                file_bytes.push_back(MARKER_SOF0);
                file_bytes.push_back(8'h00);
                file_bytes.push_back(8'h11);
                file_bytes.push_back(8'h08);
                file_bytes.push_back(hgt[15:8]);
                file_bytes.push_back(hgt[7:0]);
                file_bytes.push_back(wid[15:8]);
                file_bytes.push_back(wid[7:0]);
                repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    k = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[k] = 8'($urandom);
                end else if (r < 22) begin
                    n = $urandom_range(1, file_bytes.size() - 1);
                    while (file_bytes.size() > n) void'(file_bytes.pop_back());
                end
            end
        end
    endtask

    task check_report;
        t_size_report want;
        t_size_report seen;
        begin
            seen = '{t_status'(o_status), o_height, o_width, o_padded_width};
            reports_seen++;
            if (seen.st == ST_OK) ok_seen++;
            if (pending_reports.size() == 0) begin
                if (n_errors < 10)
                    $display("unexpected report: status %0d height %0d width %0d padded %0d",
                             seen.st, seen.h, seen.w, seen.pw);
                n_errors++;
            end else begin
                want = pending_reports.pop_front();
                if (seen.st !== want.st || seen.h !== want.h || seen.w !== want.w ||
                    seen.pw !== want.pw) begin
                    if (n_errors < 10)
                        $display("mismatch st/h/w/pw: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.st, want.h, want.w, want.pw,
                                 seen.st, seen.h, seen.w, seen.pw);
                    n_errors++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_report();
        if (!i_rst_n || hold_off) i_out_ready <= 1'b0;
        else if (cycle_count >= 1200 && cycle_count < 1800) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 99) >= GAP_PCT);
    end

    // The result side refuses everything for a while so the input side has to back up.
    initial begin
        wait (bytes_sent >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++)
            offer_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].known,
                       directed_rows[i].rep);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        while (bytes_sent < N_DIRECTED + RANDOM_BYTES) begin
            if (!drained_mid && bytes_sent >= 1200) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_reports.size() != 0);
                drained_mid = 1'b1;
            end
            build_file();
            foreach (file_bytes[k])
                offer_byte(file_bytes[k], k == file_bytes.size() - 1, 1'b0, REP_NONE);
        end
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("scanned %0d files in %0d bytes; %0d size reports checked, %0d with a frame size",
                 files_sent, bytes_sent, reports_seen, ok_seen);
        $display("mismatches: %0d, reports still owed: %0d", n_errors, pending_reports.size());
        if (n_errors == 0 && pending_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/jhss_pkg.sv
rtl/jpeg_header_size_scanner_top.sv
rtl/jhss_checker.sv
tb/tb_jpeg_header_size_scanner_top.sv
